[rtl/core/indexed_min_heap_queue_defines.svh]
// Assertion macros for the indexed min-heap queue.
`ifndef INDEXED_MIN_HEAP_QUEUE_DEFINES_SVH
`define INDEXED_MIN_HEAP_QUEUE_DEFINES_SVH

// Check outside reset.
`define IMHQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// Check at every edge, reset included.
`define IMHQ_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`endif

[rtl/core/imhq_pkg.sv]
`default_nettype none
package imhq_pkg;

  localparam logic [1:0] OP_PUSH   = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_ADJUST = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_ABSENT = 2'd3;

  localparam int unsigned CAP_WIDTH   = 11;
  localparam int unsigned ID_PORT_W   = 10;
  localparam int unsigned KEY_PORT_W  = 32;
  localparam int unsigned CNT_PORT_W  = 11;

endpackage
`default_nettype wire

[rtl/core/indexed_min_heap_queue.sv]
// Indexed binary min-heap queue of (key, id) words. One word is taken at a
// time; in_ready is low while it is worked on. A sift steps one heap level
// through S_SU_CHK and S_SU_CMP going up and through S_SD_CHK, S_SD_L and
// S_SD_R going down, all through one read and one write port on the heap
// memory. The result sits in an output register so the next word may enter
// while it waits.
// Both memories start undefined and need no clearing after reset.
`default_nettype none
module indexed_min_heap_queue
  import imhq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 1024,
  parameter int unsigned ID_COUNT    = 1024,
  parameter int unsigned KEY_WIDTH   = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [1:0]            in_opcode,
  input  wire logic [ID_PORT_W-1:0]  in_item_id,
  input  wire logic [KEY_PORT_W-1:0] in_item_key,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [1:0]                 out_status,
  output logic [ID_PORT_W-1:0]       out_id,
  output logic [KEY_PORT_W-1:0]      out_key,
  output logic [CNT_PORT_W-1:0]      out_count,
  input  wire logic                  cfg_we,
  input  wire logic [CAP_WIDTH-1:0]  cfg_wdata
);

  localparam int unsigned KW = (KEY_WIDTH < KEY_PORT_W) ? KEY_WIDTH : KEY_PORT_W;
  localparam int unsigned IW = $clog2(ID_COUNT);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned EW = KW + IW;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SU_CHK = 4'd1;
  localparam logic [3:0] S_SU_CMP = 4'd2;
  localparam logic [3:0] S_POP0   = 4'd3;
  localparam logic [3:0] S_POP1   = 4'd4;
  localparam logic [3:0] S_SD_CHK = 4'd5;
  localparam logic [3:0] S_SD_L   = 4'd6;
  localparam logic [3:0] S_SD_R   = 4'd7;
  localparam logic [3:0] S_ADJ0   = 4'd8;
  localparam logic [3:0] S_ADJ1   = 4'd9;
  localparam logic [3:0] S_ADJ2   = 4'd10;
  localparam logic [3:0] S_FIN    = 4'd11;

  logic [EW-1:0] heap_mem [QUEUE_DEPTH+1];
  logic [CW-1:0] pos_mem  [ID_COUNT];

  logic [3:0]           state_r, state_nxt;
  logic [CAP_WIDTH-1:0] cap_r;
  logic [CW-1:0]        count_r, count_nxt;
  logic [CW-1:0]        k_r, k_nxt;
  logic [IW-1:0]        id_r, id_nxt;
  logic [KW-1:0]        key_r, key_nxt;
  logic [EW-1:0]        mover_r, mover_nxt;
  logic [EW-1:0]        left_r, left_nxt;
  logic [1:0]           res_status_r, res_status_nxt;
  logic [IW-1:0]        res_id_r, res_id_nxt;
  logic [KW-1:0]        res_key_r, res_key_nxt;
  logic [EW-1:0]        heap_rd_r;
  logic [CW-1:0]        pos_rd_r;

  logic                 heap_re, heap_we, pos_re, pos_we;
  logic [CW-1:0]        heap_ra, heap_wa, pos_wd;
  logic [EW-1:0]        heap_wd;
  logic [IW-1:0]        pos_ra, pos_wa;

  logic                 out_valid_r;
  logic [1:0]           out_status_r;
  logic [ID_PORT_W-1:0] out_id_r;
  logic [KEY_PORT_W-1:0] out_key_r;
  logic [CNT_PORT_W-1:0] out_count_r;

  logic [CW:0]   child, child1;
  logic [CW:0]   n_ext;
  logic [EW-1:0] pick;
  logic          id_bad, full;
  logic [KW-1:0] key_in;

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_id     = out_id_r;
  assign out_key    = out_key_r;
  assign out_count  = out_count_r;

  assign child  = {k_r, 1'b0};
  assign child1 = child + 1'b1;
  assign n_ext  = {1'b0, count_r};
  assign id_bad = 32'(in_item_id) >= ID_COUNT;
  assign full   = (32'(cap_r) < QUEUE_DEPTH) ? (32'(count_r) >= 32'(cap_r))
                                             : (32'(count_r) >= QUEUE_DEPTH);
  assign key_in = KW'(in_item_key);
  assign pick   = ((child1 <= n_ext) && (left_r[EW-1:IW] > heap_rd_r[EW-1:IW]))
                  ? heap_rd_r : left_r;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    k_nxt          = k_r;
    id_nxt         = id_r;
    key_nxt        = key_r;
    mover_nxt      = mover_r;
    left_nxt       = left_r;
    res_status_nxt = res_status_r;
    res_id_nxt     = res_id_r;
    res_key_nxt    = res_key_r;
    heap_re = 1'b0;
    heap_ra = '0;
    heap_we = 1'b0;
    heap_wa = k_r;
    heap_wd = mover_r;
    pos_re  = 1'b0;
    pos_ra  = '0;
    pos_we  = 1'b0;
    pos_wa  = mover_r[IW-1:0];
    pos_wd  = k_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          id_nxt         = IW'(in_item_id);
          key_nxt        = key_in;
          mover_nxt      = {key_in, IW'(in_item_id)};
          res_status_nxt = ST_OK;
          res_id_nxt     = '0;
          res_key_nxt    = '0;
          state_nxt      = S_FIN;
          unique case (in_opcode)
            OP_PUSH: begin
              if (id_bad) begin
                res_status_nxt = ST_ABSENT;
              end else if (full) begin
                res_status_nxt = ST_FULL;
              end else begin
                count_nxt = count_r + 1'b1;
                k_nxt     = count_r + 1'b1;
                state_nxt = S_SU_CHK;
              end
            end
            OP_POP: begin
              if (count_r == '0) begin
                res_status_nxt = ST_EMPTY;
              end else begin
                heap_re   = 1'b1;
                heap_ra   = CW'(1);
                state_nxt = S_POP0;
              end
            end
            OP_ADJUST: begin
              if (id_bad) begin
                res_status_nxt = ST_ABSENT;
              end else begin
                pos_re    = 1'b1;
                pos_ra    = IW'(in_item_id);
                state_nxt = S_ADJ0;
              end
            end
            OP_CLEAR: begin
              count_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      S_SU_CHK: begin
        if (k_r == CW'(1)) begin
          heap_we   = 1'b1;
          pos_we    = 1'b1;
          state_nxt = S_FIN;
        end else begin
          heap_re   = 1'b1;
          heap_ra   = k_r >> 1;
          state_nxt = S_SU_CMP;
        end
      end
      S_SU_CMP: begin
        heap_we = 1'b1;
        pos_we  = 1'b1;
        if (heap_rd_r[EW-1:IW] <= mover_r[EW-1:IW]) begin
          state_nxt = S_FIN;
        end else begin
          heap_wd   = heap_rd_r;
          pos_wa    = heap_rd_r[IW-1:0];
          k_nxt     = k_r >> 1;
          state_nxt = S_SU_CHK;
        end
      end
      S_POP0: begin
        res_id_nxt  = heap_rd_r[IW-1:0];
        res_key_nxt = heap_rd_r[EW-1:IW];
        heap_re     = 1'b1;
        heap_ra     = count_r;
        count_nxt   = count_r - 1'b1;
        state_nxt   = S_POP1;
      end
      S_POP1: begin
        mover_nxt = heap_rd_r;
        k_nxt     = CW'(1);
        state_nxt = (count_r == '0) ? S_FIN : S_SD_CHK;
      end
      S_SD_CHK: begin
        if (child > n_ext) begin
          heap_we   = 1'b1;
          pos_we    = 1'b1;
          state_nxt = S_FIN;
        end else begin
          heap_re   = 1'b1;
          heap_ra   = CW'(child);
          state_nxt = S_SD_L;
        end
      end
      S_SD_L: begin
        left_nxt  = heap_rd_r;
        heap_re   = (child1 <= n_ext);
        heap_ra   = CW'(child1);
        state_nxt = S_SD_R;
      end
      S_SD_R: begin
        heap_we = 1'b1;
        pos_we  = 1'b1;
        if (mover_r[EW-1:IW] <= pick[EW-1:IW]) begin
          state_nxt = S_FIN;
        end else begin
          heap_wd   = pick;
          pos_wa    = pick[IW-1:0];
          k_nxt     = (pick == left_r) && !((child1 <= n_ext) &&
                      (left_r[EW-1:IW] > heap_rd_r[EW-1:IW])) ? CW'(child)
                                                               : CW'(child1);
          state_nxt = S_SD_CHK;
        end
      end
      S_ADJ0: begin
        if ((pos_rd_r == '0) || (pos_rd_r > count_r)) begin
          res_status_nxt = ST_ABSENT;
          state_nxt      = S_FIN;
        end else begin
          heap_re   = 1'b1;
          heap_ra   = pos_rd_r;
          k_nxt     = pos_rd_r;
          state_nxt = S_ADJ1;
        end
      end
      S_ADJ1: begin
        if (heap_rd_r[IW-1:0] != id_r) begin
          res_status_nxt = ST_ABSENT;
          state_nxt      = S_FIN;
        end else if (k_r != CW'(1)) begin
          heap_re   = 1'b1;
          heap_ra   = k_r >> 1;
          state_nxt = S_ADJ2;
        end else begin
          state_nxt = S_SD_CHK;
        end
      end
      S_ADJ2: begin
        state_nxt = (key_r <= heap_rd_r[EW-1:IW]) ? S_SU_CMP : S_SD_CHK;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (heap_we) begin
      heap_mem[heap_wa] <= heap_wd;
    end
    if (heap_re) begin
      heap_rd_r <= heap_mem[heap_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[pos_wa] <= pos_wd;
    end
    if (pos_re) begin
      pos_rd_r <= pos_mem[pos_ra];
    end
  end

  always_ff @(posedge clk) begin
    k_r          <= k_nxt;
    id_r         <= id_nxt;
    key_r        <= key_nxt;
    mover_r      <= mover_nxt;
    left_r       <= left_nxt;
    res_status_r <= res_status_nxt;
    res_id_r     <= res_id_nxt;
    res_key_r    <= res_key_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cap_r       <= CAP_WIDTH'(1024);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (state_r == S_FIN && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_FIN && (!out_valid_r || out_ready)) begin
      out_status_r <= res_status_r;
      out_id_r     <= ID_PORT_W'(res_id_r);
      out_key_r    <= KEY_PORT_W'(res_key_r);
      out_count_r  <= CNT_PORT_W'(count_r);
    end
  end

endmodule
`default_nettype wire

[rtl/core/imhq_checker.sv]
`default_nettype none
`include "indexed_min_heap_queue_defines.svh"
module imhq_checker
  import imhq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 1024
) (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic [1:0]            out_status,
  input wire logic [ID_PORT_W-1:0]  out_id,
  input wire logic [KEY_PORT_W-1:0] out_key,
  input wire logic [CNT_PORT_W-1:0] out_count
);

  `IMHQ_ASSERT_ALWAYS(a_rst_clears_out, !rst_n |=> !out_valid)
  `IMHQ_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_count))
  `IMHQ_ASSERT(a_fail_zero, out_valid && out_status != ST_OK |-> out_id == '0 && out_key == '0)
  `IMHQ_ASSERT(a_empty_cnt, out_valid && out_status == ST_EMPTY |-> out_count == '0)
  `IMHQ_ASSERT(a_cnt_max, out_valid |-> 32'(out_count) <= QUEUE_DEPTH)

endmodule

bind indexed_min_heap_queue imhq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_imhq_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_ready(out_ready),
  .out_status(out_status), .out_id(out_id), .out_key(out_key), .out_count(out_count)
);
`default_nettype wire
